@@ hdl/ipv4dq_pkg.sv @@
package ipv4dq_pkg;

    localparam logic [7:0] C_CHAR_NUL  = 8'h00;
    localparam logic [7:0] C_CHAR_ZERO = 8'h30;
    localparam logic [7:0] C_CHAR_NINE = 8'h39;
    localparam logic [7:0] C_CHAR_DOT  = 8'h2E;

    localparam logic [11:0] C_OCTET_MAX   = 12'd255;
    localparam logic [11:0] C_RADIX       = 12'd10;
    localparam logic [1:0]  C_DIGITS_MAX  = 2'd3;
    localparam logic [2:0]  C_DOTS_NEEDED = 3'd3;
    localparam logic [2:0]  C_DOTS_CAP    = 3'd4;

    typedef struct packed {
        logic [7:0] octet;
        logic [1:0] digits;
        logic [2:0] dots;
        logic       err;
    } t_parse_state;

    localparam t_parse_state C_STATE_CLEAR = '{octet: 8'd0, digits: 2'd0, dots: 3'd0, err: 1'b0};

endpackage

@@ hdl/ipv4dq_step.sv @@
module ipv4dq_step (
    input  ipv4dq_pkg::t_parse_state i_state,
    input  logic [7:0]               i_char,
    output ipv4dq_pkg::t_parse_state o_state,
    output logic                     o_addr_ok
);
    import ipv4dq_pkg::*;

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] extended;

    assign is_digit = i_char inside {[C_CHAR_ZERO:C_CHAR_NINE]};
    assign digit    = 4'(i_char - C_CHAR_ZERO);
    assign extended = {4'b0, i_state.octet} * C_RADIX + {8'b0, digit};

    assign o_addr_ok = !i_state.err && (i_state.digits != 2'd0) &&
                       (i_state.dots == C_DOTS_NEEDED);

    always_comb begin
        o_state = i_state;
        if (i_char == C_CHAR_NUL) begin
            o_state = C_STATE_CLEAR;
        end else if (!i_state.err) begin
            if (is_digit) begin
                if (extended > C_OCTET_MAX || i_state.digits >= C_DIGITS_MAX) begin
                    o_state.err = 1'b1;
                end else begin
                    o_state.octet  = extended[7:0];
                    o_state.digits = i_state.digits + 2'd1;
                end
            end else if (i_char == C_CHAR_DOT) begin
                if (i_state.digits == 2'd0) begin
                    o_state.err = 1'b1;
                end else begin
                    // count saturates so that four or more dots stay invalid
                    if (i_state.dots < C_DOTS_CAP) begin
                        o_state.dots = i_state.dots + 3'd1;
                    end
                    o_state.octet  = 8'd0;
                    o_state.digits = 2'd0;
                end
            end else begin
                o_state.err = 1'b1;
            end
        end
    end

endmodule

@@ hdl/ipv4_dotted_quad_checker.sv @@
// Latency: a terminator word passes through the input register and then the output register
//   before its result shows on m_axis. Throughput: one character word per cycle; the input
//   stage stalls only when a terminator meets a result word still waiting in the output register.
// Reset (synchronous, active low) empties both stages and clears the parse state.
// Non-terminator words produce no output word.
module ipv4_dotted_quad_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] address_valid, [7:1] zero
);
    import ipv4dq_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_char;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    logic         r_out_ok;
    logic         n_ok;
    logic         is_term;
    logic         out_free;
    logic         stage_go;

    assign is_term  = (r_char == C_CHAR_NUL);
    assign out_free = !r_out_valid || m_axis_tready;
    assign stage_go = r_in_valid && (!is_term || out_free);

    assign s_axis_tready = !r_in_valid || stage_go;

    ipv4dq_step u_step (
        .i_state   (r_state),
        .i_char    (r_char),
        .o_state   (n_state),
        .o_addr_ok (n_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_CLEAR;
        end else if (stage_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && is_term) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && is_term) begin
            r_out_ok <= n_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_ok};

    a_clear_after_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_go && is_term |=> r_state == C_STATE_CLEAR)
        else $error("parse state not cleared after terminator");

    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digits <= C_DIGITS_MAX && r_state.dots <= C_DOTS_CAP)
        else $error("digit or dot count out of range");

    a_empty_octet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digits == 2'd0 |-> r_state.octet == 8'd0)
        else $error("octet value without digits");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_ok))
        else $error("pending result lost");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err && !(stage_go && is_term) |=> r_state.err)
        else $error("error flag dropped inside a string");

endmodule

@@ verif/ipv4_dotted_quad_checker_monitor.sv @@
`timescale 1ns / 1ps

module ipv4_dotted_quad_checker_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [0] address_valid, [7:1] zero
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_checked,
    output int         o_valid_results
);
    import ipv4dq_pkg::*;

    t_parse_state addr_state = C_STATE_CLEAR;
    logic         verdict_queue[$];
    int           fail_count      = 0;
    int           results_checked = 0;
    int           valid_results   = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Advance the parse state by one character; a terminator queues a verdict.
    task automatic parse_address_char(input logic [7:0] ch);
        int next_value;
        if (ch == C_CHAR_NUL) begin
            verdict_queue.push_back(!addr_state.err && addr_state.digits != 2'd0 &&
                                    addr_state.dots == C_DOTS_NEEDED);
            addr_state = C_STATE_CLEAR;
        end else if (!addr_state.err) begin
            if (ch >= C_CHAR_ZERO && ch <= C_CHAR_NINE) begin
                next_value = int'(addr_state.octet) * int'(C_RADIX) + int'(ch) - int'(C_CHAR_ZERO);
                if (next_value > int'(C_OCTET_MAX) || addr_state.digits >= C_DIGITS_MAX) begin
                    addr_state.err = 1'b1;
                end else begin
                    addr_state.octet  = 8'(next_value);
                    addr_state.digits = addr_state.digits + 2'd1;
                end
            end else if (ch == C_CHAR_DOT) begin
                if (addr_state.digits == 2'd0) begin
                    addr_state.err = 1'b1;
                end else begin
                    if (addr_state.dots < C_DOTS_CAP)
                        addr_state.dots = addr_state.dots + 3'd1;
                    addr_state.octet  = 8'd0;
                    addr_state.digits = 2'd0;
                end
            end else begin
                addr_state.err = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        logic want_valid;
        if (!i_rst_n) begin
            addr_state = C_STATE_CLEAR;
            verdict_queue.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no verdict pending",
                                              i_m_axis_tdata));
                end else begin
                    want_valid = verdict_queue.pop_front();
                    results_checked++;
                    if (i_m_axis_tdata[0] === 1'b1)
                        valid_results++;
                    if (i_m_axis_tdata[0] !== want_valid)
                        report_mismatch($sformatf("address_valid %b, predicted %b",
                                                  i_m_axis_tdata[0], want_valid));
                    if (i_m_axis_tdata[7:1] !== 7'd0)
                        report_mismatch($sformatf("pad bits %b, predicted zero",
                                                  i_m_axis_tdata[7:1]));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                parse_address_char(i_s_axis_tdata);
        end
        o_fail_count      <= fail_count;
        o_pending         <= verdict_queue.size();
        o_results_checked <= results_checked;
        o_valid_results   <= valid_results;
    end

endmodule

@@ verif/ipv4_dotted_quad_checker_test.sv @@
`timescale 1ns / 1ps

module ipv4_dotted_quad_checker_test;
    import ipv4dq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int WORD_TARGET  = 740;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] char_in
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [0] address_valid, [7:1] zero

    int fail_count;
    int pending;
    int results_checked;
    int valid_results;

    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    int words_sent     = 0;
    int strings_sent   = 0;
    int cycle_count    = 0;

    ipv4_dotted_quad_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ipv4_dotted_quad_checker_monitor quad_monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_axis_tvalid   (s_axis_tvalid),
        .i_s_axis_tready   (s_axis_tready),
        .i_s_axis_tdata    (s_axis_tdata),
        .i_m_axis_tvalid   (m_axis_tvalid),
        .i_m_axis_tready   (m_axis_tready),
        .i_m_axis_tdata    (m_axis_tdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_valid_results   (valid_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall before each word while receiver_idles is set
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = receiver_idles ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    task automatic send_word(input logic [7:0] ch);
        int gap;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge i_clk iff s_axis_tready);
        words_sent++;
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        foreach (text[i])
            send_word(text[i]);
        send_word(C_CHAR_NUL);
        strings_sent++;
    endtask

    task automatic send_ascii(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text(text);
    endtask

    // hold off input until every verdict is back; the monitor's pending count is registered
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic void append_number(ref logic [7:0] text[$], input int value,
                                          input int width);
        int digits[$];
        int v;
        v = value;
        do begin
            digits.push_front(v % 10);
            v = v / 10;
        end while (v > 0);
        while (digits.size() < width)
            digits.push_front(0);
        foreach (digits[i])
            text.push_back(C_CHAR_ZERO + 8'(digits[i]));
    endfunction

    // Mostly dotted quads with random octets; some with one damaged octet,
    // the wrong octet count, a stray byte, or plain noise.
    function automatic void make_address(ref logic [7:0] text[$]);
        int kind;
        int octets;
        int bad;
        int pos;
        text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(0, 10))
                text.push_back(8'($urandom_range(1, 255)));
            return;
        end
        octets = (kind < 25) ? $urandom_range(1, 6) : 4;
        bad    = $urandom_range(0, octets - 1);
        for (int i = 0; i < octets; i++) begin
            if (i > 0)
                text.push_back(C_CHAR_DOT);
            if (i == bad && kind >= 25 && kind < 35)
                append_number(text, $urandom_range(250, 260), 1);
            else if (i == bad && kind >= 35 && kind < 43)
                append_number(text, $urandom_range(0, 255), 4);
            else if (!(i == bad && kind >= 43 && kind < 50))
                append_number(text, $urandom_range(0, 255), $urandom_range(1, 3));
        end
        if (kind >= 50 && kind < 60) begin
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = 8'($urandom_range(1, 255));
        end else if (kind >= 60 && kind < 65) begin
            pos = $urandom_range(0, text.size());
            text.insert(pos, 8'($urandom_range(1, 255)));
        end
    endfunction

    initial begin
        logic [7:0] text[$];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, overflow, fourth digit, empty octet, junk after error
        send_ascii("255.0.9.1");
        send_ascii("");
        send_ascii("256");
        send_ascii("0000");
        send_ascii(".\377");
        send_ascii("9:");
        drain_results();

        while (words_sent < WORD_TARGET) begin
            if (strings_sent % 16 == 0) begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            if (strings_sent % 40 == 20)
                drain_results();
            make_address(text);
            send_text(text);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d address strings in %0d words under random stalls on both sides.",
                 strings_sent, words_sent);
        $display("Checked %0d verdicts, %0d of them valid addresses.",
                 results_checked, valid_results);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
